// File: rtl/djss_pkg.sv
// Shared payload types and widths for the deadline job slot scheduler.
`default_nettype none
package djss_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned SLOT_W  = 7;

	typedef struct packed {
		logic [FIELD_W-1:0] deadline;
		logic [FIELD_W-1:0] profit;
		logic               last_job;
	} djss_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] job_index;
		logic [FIELD_W-1:0] job_deadline;
		logic [FIELD_W-1:0] job_profit;
		logic [SLOT_W-1:0]  slot;
		logic               last_result;
	} djss_out_t;

endpackage
`default_nettype wire

// File: rtl/deadline_job_slot_scheduler_unit.sv
// Top level: job store, selection sequencer and slot allocator.
// Load: one word per cycle while idle; the word marked last_job starts a run.
// Run: for each of n results the sequencer scans all stored jobs, one per cycle, with
// one shared compare unit, then places the chosen job in a slot and emits its word.
// Reset clears the job count, slot map and control; job stores are not reset.
`default_nettype none
module deadline_job_slot_scheduler_unit
	import djss_pkg::*;
#(
	parameter int unsigned MAX_JOBS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire djss_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output djss_out_t      out_data
);

	localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned CW = $clog2(MAX_JOBS + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_PLACE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Job stores, one read port each
	logic [FIELD_W-1:0] dl_mem [MAX_JOBS];
	logic [FIELD_W-1:0] pr_mem [MAX_JOBS];
	logic [FIELD_W-1:0] rd_dl, rd_pr;

	logic [CW-1:0] count_q;
	logic [CW-1:0] emitted_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] rd_addr;
	logic          rd_live_q;
	logic [AW-1:0] rd_idx_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [MAX_JOBS-1:0] taken_q;

	// Best candidate so far: highest profit, earliest load on ties
	logic          best_ok_q;
	logic [AW-1:0] best_idx_q;
	logic [FIELD_W-1:0] best_pr_q;
	logic [FIELD_W-1:0] best_dl_q;

	logic [FIELD_W-1:0] lim;
	logic [MAX_JOBS-1:0] free_mask;
	logic          found;
	logic [AW-1:0] found_pos;
	logic          load_fire;

	assign in_ready  = (state_q == ST_LOAD);
	assign load_fire = in_valid && in_ready;
	assign rd_addr   = scan_q;

	// Store loaded jobs and read the scanned entry
	always_ff @(posedge clk) begin
		if (load_fire && (count_q < CW'(MAX_JOBS))) begin
			dl_mem[count_q[AW-1:0]] <= in_data.deadline;
			pr_mem[count_q[AW-1:0]] <= in_data.profit;
		end
		rd_dl <= dl_mem[rd_addr];
		rd_pr <= pr_mem[rd_addr];
	end

	// Latest free slot at or before min(deadline, count)
	always_comb begin
		lim = (best_dl_q > FIELD_W'(count_q)) ? FIELD_W'(count_q) : best_dl_q;
		for (int t = 0; t < MAX_JOBS; t++) begin
			free_mask[t] = !taken_q[t] && (FIELD_W'(t) < lim);
		end
		found     = 1'b0;
		found_pos = '0;
		for (int t = 0; t < MAX_JOBS; t++) begin
			if (free_mask[t]) begin
				found     = 1'b1;
				found_pos = AW'(t);
			end
		end
	end

	// Sequencer: load, scan for next job, place it, hand out the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			emitted_q <= '0;
			scan_q    <= '0;
			rd_live_q <= 1'b0;
			rd_idx_q  <= '0;
			done_q    <= '0;
			taken_q   <= '0;
			best_ok_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_fire) begin
						logic [CW-1:0] n_next;
						n_next = (count_q < CW'(MAX_JOBS)) ? count_q + 1'b1 : count_q;
						count_q <= n_next;
						if (in_data.last_job) begin
							state_q   <= ST_SCAN;
							scan_q    <= '0;
							rd_live_q <= 1'b0;
							best_ok_q <= 1'b0;
							done_q    <= '0;
							taken_q   <= '0;
							emitted_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					// advance read address, compare the entry that arrived
					rd_live_q <= (CW'(scan_q) < count_q);
					rd_idx_q  <= scan_q;
					if (CW'(scan_q) < count_q) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_live_q && !done_q[rd_idx_q] &&
					    (!best_ok_q || (rd_pr > best_pr_q))) begin
						best_ok_q  <= 1'b1;
						best_idx_q <= rd_idx_q;
						best_pr_q  <= rd_pr;
						best_dl_q  <= rd_dl;
					end
					if (!rd_live_q && (CW'(scan_q) >= count_q || scan_q == AW'(MAX_JOBS - 1))
					    && rd_idx_q != '0 || (!rd_live_q && count_q == '0)) begin
						state_q <= ST_PLACE;
					end
					if (rd_live_q && CW'(rd_idx_q) + 1'b1 == count_q) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					out_data.job_index    <= INDEX_W'(best_idx_q);
					out_data.job_deadline <= best_dl_q;
					out_data.job_profit   <= best_pr_q;
					out_data.slot         <= found ? SLOT_W'(found_pos) + 1'b1 : '0;
					out_data.last_result  <= (emitted_q + 1'b1 == count_q);
					if (found) begin
						taken_q[found_pos] <= 1'b1;
					end
					done_q[best_idx_q] <= 1'b1;
					out_valid <= best_ok_q;
					state_q   <= best_ok_q ? ST_EMIT : ST_LOAD;
					if (!best_ok_q) begin
						count_q <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						emitted_q <= emitted_q + 1'b1;
						scan_q    <= '0;
						rd_live_q <= 1'b0;
						best_ok_q <= 1'b0;
						if (emitted_q + 1'b1 == count_q) begin
							state_q <= ST_LOAD;
							count_q <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: verif/tb_deadline_job_slot_scheduler_unit.sv
// Testbench for the deadline job slot scheduler: random job sets, scoreboarded results.
`default_nettype none
module tb_deadline_job_slot_scheduler_unit
	import djss_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned JOB_CAP = 64;

	// Predicts the schedule of each job set and checks result words in order.
	class job_schedule_board;
		logic [FIELD_W-1:0] held_deadline[JOB_CAP];
		logic [FIELD_W-1:0] held_profit[JOB_CAP];
		int unsigned held_count;
		djss_out_t pending_results[$];
		int unsigned mismatches;

		function new();
			held_count = 0;
			mismatches = 0;
		endfunction

		// Note one accepted job word; a last mark schedules the held set.
		function void note_job(djss_in_t w);
			int unsigned rank[JOB_CAP];
			bit taken[JOB_CAP];
			int unsigned i, j, key, lim, s, t;
			djss_out_t r;
			if (held_count < JOB_CAP) begin
				held_deadline[held_count] = w.deadline;
				held_profit[held_count] = w.profit;
				held_count++;
			end
			if (!w.last_job)
				return;
			// stable insertion by profit, highest first
			for (i = 0; i < held_count; i++) begin
				key = i;
				j = i;
				while (j > 0 && held_profit[rank[j-1]] < held_profit[key]) begin
					rank[j] = rank[j-1];
					j--;
				end
				rank[j] = key;
			end
			for (i = 0; i < JOB_CAP; i++)
				taken[i] = 1'b0;
			// latest free slot at or before the clamped deadline
			for (i = 0; i < held_count; i++) begin
				lim = 32'(held_deadline[rank[i]]);
				if (lim > held_count)
					lim = held_count;
				s = 0;
				for (t = lim; t >= 1; t--) begin
					if (!taken[t-1]) begin
						taken[t-1] = 1'b1;
						s = t;
						break;
					end
				end
				r.job_index = INDEX_W'(rank[i]);
				r.job_deadline = held_deadline[rank[i]];
				r.job_profit = held_profit[rank[i]];
				r.slot = SLOT_W'(s);
				r.last_result = (i + 1 == held_count);
				pending_results.push_back(r);
			end
			held_count = 0;
		endfunction

		function void check_result(djss_out_t got);
			djss_out_t exp;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			exp = pending_results.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: exp idx %0d dl %0d pr %0d slot %0d last %0d,",
						" got idx %0d dl %0d pr %0d slot %0d last %0d"},
						exp.job_index, exp.job_deadline, exp.job_profit, exp.slot,
						exp.last_result, got.job_index, got.job_deadline,
						got.job_profit, got.slot, got.last_result);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	djss_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	djss_out_t out_data;
	job_schedule_board board = new();
	bit stim_done = 0;

	deadline_job_slot_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(5, 40);
	endfunction

	// Send one job word, with an optional idle gap ahead of it; valid stays up otherwise.
	task automatic send_job(logic [15:0] dl, logic [15:0] pr, logic lst, bit gaps);
		int unsigned g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{deadline: dl, profit: pr, last_job: lst};
		do @(posedge clk); while (!in_ready);
		board.note_job(in_data);
	endtask

	// Random set of n jobs: deadlines mostly up to dmax, some zero or full-range; profits mostly small.
	task automatic send_set(int unsigned n, bit gaps, int unsigned dmax);
		int unsigned i;
		logic [15:0] dl, pr;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: dl = 16'($urandom);
				1: dl = '0;
				default: dl = 16'($urandom_range(0, dmax));
			endcase
			pr = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
			send_job(dl, pr, i == n - 1, gaps);
		end
	endtask

	// Accept result words with random stalls, and stretches of none.
	initial begin
		int unsigned g;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g != 0) begin
					out_ready <= 0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1;
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result(out_data);
		end
	end

	initial begin
		int unsigned items, n;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: single job, zero deadline, field extremes, ties
		send_job(16'd0, 16'hFFFF, 1'b1, 0);
		send_job(16'd1, 16'd0, 1'b1, 0);
		send_job(16'hFFFF, 16'hFFFF, 1'b0, 0);
		send_job(16'd0, 16'hFFFF, 1'b0, 0);
		send_job(16'd1, 16'h5555, 1'b0, 0);
		send_job(16'd2, 16'hAAAA, 1'b0, 0);
		send_job(16'd2, 16'h5555, 1'b0, 0);
		send_job(16'h8000, 16'h0000, 1'b1, 0);
		send_job(16'd3, 16'd7, 1'b0, 0);
		send_job(16'd3, 16'd7, 1'b0, 0);
		send_job(16'd3, 16'd7, 1'b0, 0);
		send_job(16'd1, 16'd7, 1'b1, 0);
		items = 12;
		// full set, then overfull with the mark on a dropped job
		send_set(JOB_CAP, 1, 70);
		send_set(JOB_CAP + 3, 0, 70);
		items += 2 * JOB_CAP + 3;
		while (items < 330) begin
			n = $urandom_range(1, 12);
			send_set(n, $urandom_range(0, 2) != 0, n + 2);
			items += n;
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
